/* sv/bch_44_32_syndrome_table_decoder_unit_defines.svh */
// assertion macros for the bch(44,32) syndrome table decoder
// expects clk and rst_n in the scope of each use
`ifndef BCH_44_32_SYNDROME_TABLE_DECODER_UNIT_DEFINES_SVH
`define BCH_44_32_SYNDROME_TABLE_DECODER_UNIT_DEFINES_SVH

// expression holds at every edge out of reset
`define BCHD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BCHD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/bchd_pkg.sv */
// shared types, constants and syndrome function for the bch(44,32) decoder
// no dependencies
package bchd_pkg;

  localparam int CODE_W      = 44;
  localparam int PARITY_W    = 12;
  localparam int TABLE_DEPTH = 1 << PARITY_W;
  localparam int TBL_W       = CODE_W + 1;

  typedef logic [CODE_W-1:0]   bchd_word_t;
  typedef logic [PARITY_W-1:0] bchd_syn_t;

  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_LOAD   = 1'b1
  } bchd_mode_t;

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_UNCORR    = 2'd2
  } bchd_status_t;

  // queue word: a classified item waiting for the back end
  typedef struct packed {
    logic       is_load;
    bchd_syn_t  syn;
    bchd_word_t data;
  } bchd_entry_t;

  // queue flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } bchd_q_stat_t;

  localparam bchd_word_t ONE = bchd_word_t'(1);

  // parity-check rows, one mask per syndrome bit
  localparam bchd_word_t CHECK_ROWS [PARITY_W] = '{
    ONE<<0 | ONE<<12 | ONE<<15 | ONE<<16 | ONE<<17 | ONE<<18 | ONE<<21 | ONE<<22 |
      ONE<<24 | ONE<<28 | ONE<<29 | ONE<<33 | ONE<<34 | ONE<<36 | ONE<<37 | ONE<<38 |
      ONE<<39 | ONE<<40 | ONE<<41,
    ONE<<1 | ONE<<13 | ONE<<16 | ONE<<17 | ONE<<18 | ONE<<19 | ONE<<22 | ONE<<23 |
      ONE<<25 | ONE<<29 | ONE<<30 | ONE<<34 | ONE<<35 | ONE<<37 | ONE<<38 | ONE<<39 |
      ONE<<40 | ONE<<41 | ONE<<42,
    ONE<<2 | ONE<<12 | ONE<<14 | ONE<<15 | ONE<<16 | ONE<<19 | ONE<<20 | ONE<<21 |
      ONE<<22 | ONE<<23 | ONE<<26 | ONE<<28 | ONE<<29 | ONE<<30 | ONE<<31 | ONE<<33 |
      ONE<<34 | ONE<<35 | ONE<<37 | ONE<<42 | ONE<<43,
    ONE<<3 | ONE<<13 | ONE<<15 | ONE<<16 | ONE<<17 | ONE<<20 | ONE<<21 | ONE<<22 |
      ONE<<23 | ONE<<24 | ONE<<27 | ONE<<29 | ONE<<30 | ONE<<31 | ONE<<32 | ONE<<34 |
      ONE<<35 | ONE<<36 | ONE<<38 | ONE<<43,
    ONE<<4 | ONE<<12 | ONE<<14 | ONE<<15 | ONE<<23 | ONE<<25 | ONE<<29 | ONE<<30 |
      ONE<<31 | ONE<<32 | ONE<<34 | ONE<<35 | ONE<<38 | ONE<<40 | ONE<<41,
    ONE<<5 | ONE<<13 | ONE<<15 | ONE<<16 | ONE<<24 | ONE<<26 | ONE<<30 | ONE<<31 |
      ONE<<32 | ONE<<33 | ONE<<35 | ONE<<36 | ONE<<39 | ONE<<41 | ONE<<42,
    ONE<<6 | ONE<<14 | ONE<<16 | ONE<<17 | ONE<<25 | ONE<<27 | ONE<<31 | ONE<<32 |
      ONE<<33 | ONE<<34 | ONE<<36 | ONE<<37 | ONE<<40 | ONE<<42 | ONE<<43,
    ONE<<7 | ONE<<12 | ONE<<16 | ONE<<21 | ONE<<22 | ONE<<24 | ONE<<26 | ONE<<29 |
      ONE<<32 | ONE<<35 | ONE<<36 | ONE<<39 | ONE<<40 | ONE<<43,
    ONE<<8 | ONE<<12 | ONE<<13 | ONE<<15 | ONE<<16 | ONE<<18 | ONE<<21 | ONE<<23 |
      ONE<<24 | ONE<<25 | ONE<<27 | ONE<<28 | ONE<<29 | ONE<<30 | ONE<<34 | ONE<<38 |
      ONE<<39,
    ONE<<9 | ONE<<12 | ONE<<13 | ONE<<14 | ONE<<15 | ONE<<18 | ONE<<19 | ONE<<21 |
      ONE<<25 | ONE<<26 | ONE<<30 | ONE<<31 | ONE<<33 | ONE<<34 | ONE<<35 | ONE<<36 |
      ONE<<37 | ONE<<38 | ONE<<41,
    ONE<<10 | ONE<<13 | ONE<<14 | ONE<<15 | ONE<<16 | ONE<<19 | ONE<<20 | ONE<<22 |
      ONE<<26 | ONE<<27 | ONE<<31 | ONE<<32 | ONE<<34 | ONE<<35 | ONE<<36 | ONE<<37 |
      ONE<<38 | ONE<<39 | ONE<<42,
    ONE<<11 | ONE<<14 | ONE<<15 | ONE<<16 | ONE<<17 | ONE<<20 | ONE<<21 | ONE<<23 |
      ONE<<27 | ONE<<28 | ONE<<32 | ONE<<33 | ONE<<35 | ONE<<36 | ONE<<37 | ONE<<38 |
      ONE<<39 | ONE<<40 | ONE<<43
  };

  // one xor tree per syndrome bit
  function automatic bchd_syn_t syndrome_of(input bchd_word_t word);
    bchd_syn_t s;
    for (int i = 0; i < PARITY_W; i++) begin
      s[i] = ^(word & CHECK_ROWS[i]);
    end
    return s;
  endfunction

endpackage

/* sv/bchd_fifo.sv */
// short queue between the front end and the back end of the decoder
// depends on bchd_pkg for the entry and flag types
module bchd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bchd_pkg::bchd_entry_t push_entry,
  input  logic                  pop,
  output bchd_pkg::bchd_entry_t head,
  output bchd_pkg::bchd_q_stat_t q_stat
);
  import bchd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bchd_entry_t            slot_mem [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  // flags and head word
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = slot_mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* sv/bchd_front.sv */
// front end: accepts input words, forms the syndrome and classifies load vs decode
// depends on bchd_pkg for the syndrome function and queue types
module bchd_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [43:0]            in_codeword,
  input  logic [11:0]            in_load_syndrome,
  input  logic [43:0]            in_load_pattern,
  input  bchd_pkg::bchd_q_stat_t q_stat,
  input  logic                   clr_busy,
  output logic                   push,
  output bchd_pkg::bchd_entry_t  push_entry
);
  import bchd_pkg::*;

  // hold off while the queue is full or the table is being cleared
  assign in_stall = q_stat.full || clr_busy;
  assign push     = in_valid && !in_stall;

  // a load carries its address and pattern, a decode its syndrome and word
  always_comb begin
    push_entry.is_load = (in_mode == MODE_LOAD);
    if (in_mode == MODE_LOAD) begin
      push_entry.syn  = in_load_syndrome;
      push_entry.data = in_load_pattern;
    end else begin
      push_entry.syn  = syndrome_of(in_codeword);
      push_entry.data = in_codeword;
    end
  end

endmodule

/* sv/bchd_back.sv */
// back end: error-pattern table, table clear after reset, lookup and result register
// depends on bchd_pkg for the table sizes, entry type and status codes
module bchd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bchd_pkg::bchd_entry_t  head,
  input  bchd_pkg::bchd_q_stat_t q_stat,
  output logic                   pop,
  output logic                   clr_busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [43:0]            out_corrected_word,
  output logic [11:0]            out_syndrome_value,
  output logic [1:0]             out_status
);
  import bchd_pkg::*;

  // table entry: valid mark on top of the pattern
  logic [TBL_W-1:0] table_mem [TABLE_DEPTH];
  logic [TBL_W-1:0] mem_q_r;

  logic             clr_busy_r, clr_busy_nxt;
  bchd_syn_t        clr_addr_r, clr_addr_nxt;

  logic             rd_valid_r, rd_valid_nxt;
  bchd_word_t       rd_word_r, rd_word_nxt;
  bchd_syn_t        rd_syn_r, rd_syn_nxt;

  logic             out_valid_r, out_valid_nxt;
  bchd_word_t       out_word_r, out_word_nxt;
  bchd_syn_t        out_syn_r, out_syn_nxt;
  bchd_status_t     out_status_r, out_status_nxt;

  logic             out_free;
  logic             rd_adv;
  logic             pop_dec;
  logic             pop_load;

  // handshake between lookup stage, result register and queue
  assign out_free = !out_valid_r || !out_stall;
  assign rd_adv   = rd_valid_r && out_free;
  assign pop      = !q_stat.empty && !clr_busy_r &&
                    (head.is_load || !rd_valid_r || rd_adv);
  assign pop_dec  = pop && !head.is_load;
  assign pop_load = pop && head.is_load;
  assign clr_busy = clr_busy_r;

  // clear sweep over all valid marks after reset
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + PARITY_W'(1);
      if (clr_addr_r == '1) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // table write: clear sweep or load, read on decode
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      table_mem[clr_addr_r] <= '0;
    end else if (pop_load) begin
      table_mem[head.syn] <= {1'b1, head.data};
    end
  end

  always_ff @(posedge clk) begin
    if (pop_dec) begin
      mem_q_r <= table_mem[head.syn];
    end
  end

  // lookup stage holds the decode word while its table read lands
  always_comb begin
    rd_valid_nxt = rd_valid_r;
    rd_word_nxt  = rd_word_r;
    rd_syn_nxt   = rd_syn_r;
    if (pop_dec) begin
      rd_valid_nxt = 1'b1;
      rd_word_nxt  = head.data;
      rd_syn_nxt   = head.syn;
    end else if (rd_adv) begin
      rd_valid_nxt = 1'b0;
    end
  end

  // correction and status into the result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_syn_nxt    = out_syn_r;
    out_status_nxt = out_status_r;
    if (rd_adv) begin
      out_valid_nxt = 1'b1;
      out_syn_nxt   = rd_syn_r;
      if (rd_syn_r == '0) begin
        out_word_nxt   = rd_word_r;
        out_status_nxt = ST_CLEAN;
      end else if (mem_q_r[TBL_W-1]) begin
        out_word_nxt   = rd_word_r ^ mem_q_r[CODE_W-1:0];
        out_status_nxt = ST_CORRECTED;
      end else begin
        out_word_nxt   = rd_word_r;
        out_status_nxt = ST_UNCORR;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_word_r    <= rd_word_nxt;
    rd_syn_r     <= rd_syn_nxt;
    out_word_r   <= out_word_nxt;
    out_syn_r    <= out_syn_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_corrected_word = out_word_r;
  assign out_syndrome_value = out_syn_r;
  assign out_status         = out_status_r;

endmodule

/* sv/bch_44_32_syndrome_table_decoder_unit.sv */
// top level of the bch(44,32) syndrome table decoder
// depends on bchd_pkg, bchd_front, bchd_fifo, bchd_back and the defines header
`include "bch_44_32_syndrome_table_decoder_unit_defines.svh"

// Decodes 44-bit BCH(44,32) words one per clock cycle while out_stall is low.
// Each decode word gets a 12-bit syndrome from fixed xor trees; a zero syndrome
// passes the word as clean, otherwise the syndrome reads a 4096-entry
// error-pattern table and the word is corrected on a loaded entry or flagged
// uncorrectable. Load words (mode 1) write one table entry and give no result.
// After reset the table's valid marks are cleared by a sweep over all 4096
// entries, one entry per cycle, with in_stall held high. After that the sustained
// rate is one word per cycle while out_stall is low, set by the single table port
// that serves one load write or one decode read each cycle; a decode result passes
// from its queue slot through the lookup stage (table read) to the result register.
module bch_44_32_syndrome_table_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [43:0] in_codeword,
  input  logic [11:0] in_load_syndrome,
  input  logic [43:0] in_load_pattern,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [43:0] out_corrected_word,
  output logic [11:0] out_syndrome_value,
  output logic [1:0]  out_status
);
  import bchd_pkg::*;

  bchd_q_stat_t q_stat;
  bchd_entry_t  push_entry;
  bchd_entry_t  head;
  logic         q_push;
  logic         q_pop;
  logic         clr_busy;

  // intake and syndrome
  bchd_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_codeword      (in_codeword),
    .in_load_syndrome (in_load_syndrome),
    .in_load_pattern  (in_load_pattern),
    .q_stat           (q_stat),
    .clr_busy         (clr_busy),
    .push             (q_push),
    .push_entry       (push_entry)
  );

  // decoupling queue
  bchd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // table, lookup and result
  bchd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_stat             (q_stat),
    .pop                (q_pop),
    .clr_busy           (clr_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_corrected_word (out_corrected_word),
    .out_syndrome_value (out_syndrome_value),
    .out_status         (out_status)
  );

  // checks
  `BCHD_ASSERT_IMPLIES(a_no_push_in_clear, clr_busy, !q_push, "word queued during table clear")
  `BCHD_ASSERT_IMPLIES(a_clean_iff_zero, out_valid,
    ((out_syndrome_value == '0) == (out_status == ST_CLEAN)),
    "status clean does not match zero syndrome")
  `BCHD_ASSERT_ALWAYS(a_queue_flags, !(q_stat.full && q_stat.empty), "queue full and empty at once")

endmodule
